// ===== sv/vector_distance_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the vector distance unit
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef VECTOR_DISTANCE_UNIT_ASSERT_SVH
`define VECTOR_DISTANCE_UNIT_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define VDU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define VDU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/vdu_pkg.sv =====
// ----------------------------------------------------------------------------
// vdu_pkg
// Shared constants and types of the vector distance unit.
// ----------------------------------------------------------------------------
package vdu_pkg;

	localparam int COORD_W_DEF = 16;
	localparam int SUM_W       = 40;
	localparam int DIST_W      = 23;
	localparam int OUT_TDATA_W = ((DIST_W + 7) / 8) * 8;
	localparam int ROOT_W      = SUM_W / 2;
	localparam int QDEPTH      = 2;

	localparam logic METRIC_MANHATTAN = 1'b0;
	localparam logic METRIC_EUCLID    = 1'b1;

	// one finished vector handed from front to back
	typedef struct packed {
		logic             euclid;
		logic [SUM_W-1:0] sum;
	} vdu_entry_t;

	typedef struct packed {
		logic       push;
		vdu_entry_t entry;
	} vdu_push_t;

endpackage

// ===== sv/vdu_front.sv =====
// ----------------------------------------------------------------------------
// vdu_front
// Takes coordinate pairs, forms |d| or d*d and keeps the saturating sum.
// ----------------------------------------------------------------------------
module vdu_front import vdu_pkg::*; #(
	parameter int COORD_WIDTH = COORD_W_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [COORD_WIDTH-1:0] sample,
	input  logic [COORD_WIDTH-1:0] centroid,
	input  logic                   last,
	input  logic                   mode,
	input  logic                   q_full,
	output vdu_push_t              push
);

	localparam int TERM_W = 2 * COORD_WIDTH;
	localparam int ACC_W  = ((TERM_W > SUM_W) ? TERM_W : SUM_W) + 1;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	logic signed [COORD_WIDTH:0] diff;
	logic [COORD_WIDTH-1:0]      mag;
	logic                        advance;

	logic                   v_s1, last_s1, mode_s1;
	logic [COORD_WIDTH-1:0] mag_s1;
	logic                   v_s2, last_s2, mode_s2;
	logic [TERM_W-1:0]      term_s2;

	logic [SUM_W-1:0] sum_q;
	logic [ACC_W-1:0] acc;
	logic [SUM_W-1:0] sum_next;

	assign diff = $signed({sample[COORD_WIDTH-1], sample})
		- $signed({centroid[COORD_WIDTH-1], centroid});
	// magnitude always fits COORD_WIDTH bits unsigned
	assign mag = diff[COORD_WIDTH] ? COORD_WIDTH'(-diff) : diff[COORD_WIDTH-1:0];

	// only a finished vector facing a full queue holds the pipe
	assign advance  = !(v_s2 && last_s2 && q_full);
	assign in_ready = advance;

	assign acc      = ACC_W'(sum_q) + ACC_W'(term_s2);
	assign sum_next = (acc > ACC_W'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];

	assign push.push         = advance && v_s2 && last_s2;
	assign push.entry.euclid = mode_s2;
	assign push.entry.sum    = sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			sum_q <= '0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			if (v_s2) begin
				sum_q <= last_s2 ? '0 : sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s1 <= last;
			mode_s1 <= mode;
			mag_s1  <= mag;
			last_s2 <= last_s1;
			mode_s2 <= mode_s1;
			term_s2 <= (mode_s1 == METRIC_EUCLID)
				? TERM_W'(mag_s1) * TERM_W'(mag_s1) : TERM_W'(mag_s1);
		end
	end

endmodule

// ===== sv/vdu_queue.sv =====
// ----------------------------------------------------------------------------
// vdu_queue
// Short queue of finished sums between front and back, registered read.
// ----------------------------------------------------------------------------
module vdu_queue import vdu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  vdu_push_t  push,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output vdu_entry_t rd_data
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	vdu_entry_t       mem [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push.push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push.entry;
		end
		if (do_pop) begin
			rd_data <= mem[rd_ptr_q];
		end
	end

endmodule

// ===== sv/vdu_back.sv =====
// ----------------------------------------------------------------------------
// vdu_back
// Finishes one vector: saturates the sum or takes its floor square root
// one bit per cycle, then holds the result in the output register.
// ----------------------------------------------------------------------------
module vdu_back import vdu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  vdu_entry_t        q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DIST_W-1:0] out_data
);

	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W);
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_ROOT  = 4'b0100,
		ST_HOLD  = 4'b1000
	} state_t;

	state_t            state_q;
	logic              out_valid_q;
	logic [DIST_W-1:0] out_data_q;
	logic [DIST_W-1:0] result_q;
	logic [SUM_W-1:0]  x_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [REM_W-1:0]  rem_sh, trial, rem_n;
	logic [ROOT_W-1:0] root_n;
	logic              ge;
	logic              slot_free;
	logic              load_out;

	// one result bit per step: bring down two bits, try (root << 2) | 1
	assign rem_sh = {rem_q[REM_W-3:0], x_q[SUM_W-1:SUM_W-2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = (rem_sh >= trial);
	assign rem_n  = ge ? rem_sh - trial : rem_sh;
	assign root_n = {root_q[ROOT_W-2:0], ge};

	assign slot_free = !out_valid_q || out_ready;
	assign load_out  = (state_q == ST_HOLD) && slot_free;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= q_data.euclid ? ST_ROOT : ST_HOLD;
				end
				ST_ROOT: begin
					if (cnt_q == '0) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_FETCH: begin
				x_q    <= q_data.sum;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= CNT_W'(ROOT_W - 1);
				result_q <= (q_data.sum > SUM_W'(DIST_MAX))
					? DIST_MAX : q_data.sum[DIST_W-1:0];
			end
			ST_ROOT: begin
				x_q    <= {x_q[SUM_W-3:0], 2'b00};
				rem_q  <= rem_n;
				root_q <= root_n;
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					result_q <= DIST_W'(root_n);
				end
			end
			ST_HOLD: begin
				if (slot_free) begin
					out_data_q <= result_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/vector_distance_unit.sv =====
// ----------------------------------------------------------------------------
// vector_distance_unit
// Streaming Manhattan / Euclidean distance between a sample and a centroid.
// ----------------------------------------------------------------------------
// Input stream (s_*): one coordinate pair per item, tlast on the last pair.
//   The front end takes one item every cycle while the back queue has room.
// Output stream (m_*): one distance item per vector, unsigned integer.
// Config channel (cfg_*): metric_mode, 0 Manhattan, 1 Euclidean; always
//   ready, write only while the block is idle.
// After the last item the vector passes the front stages s1 and s2, the
//   queue and the back end; in Euclidean mode the square root unit yields
//   one root bit per cycle (a 20-bit root for the 40-bit sum).
// Throughput: one coordinate per cycle while the queue has room. The back
//   end finishes one vector before it takes the next; a two-entry queue
//   absorbs bursts of short vectors, beyond that s_tready drops.
// Reset: the running sum, the queue and the output are cleared and
//   metric_mode returns to Euclidean.
// Stall: a held m_tready keeps the result in the output register; the back
//   end and then the queue fill, after which s_tready goes low.
// ----------------------------------------------------------------------------
module vector_distance_unit import vdu_pkg::*; #(
	parameter int COORD_WIDTH = COORD_W_DEF
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// sample_coord, centroid_coord, zero fill
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
	input  logic                                 s_tlast,

	output logic                   m_tvalid,
	input  logic                   m_tready,
	// distance, zero fill
	output logic [OUT_TDATA_W-1:0] m_tdata,

	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);

	logic              metric_mode_q;
	vdu_push_t         push;
	logic              q_full, q_empty, q_pop;
	vdu_entry_t        q_data;
	logic [DIST_W-1:0] distance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_mode_q <= METRIC_EUCLID;
		end else if (cfg_valid && cfg_ready) begin
			metric_mode_q <= cfg_data;
		end
	end

	vdu_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sample   (s_tdata[COORD_WIDTH-1:0]),
		.centroid (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.last     (s_tlast),
		.mode     (metric_mode_q),
		.q_full   (q_full),
		.push     (push)
	);

	vdu_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.rd_data (q_data)
	);

	vdu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (distance)
	);

	assign m_tdata = OUT_TDATA_W'(distance);

endmodule

// ===== sv/vdu_checker.sv =====
// ----------------------------------------------------------------------------
// vdu_checker
// Port-level checks: every result has a vector behind it, bounded backlog.
// ----------------------------------------------------------------------------
`include "vector_distance_unit_assert.svh"

module vdu_checker import vdu_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   s_tlast,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// two pipe stages, the queue, the back end and the output register
	localparam int PEND_MAX = QDEPTH + 4;
	localparam int PEND_W   = $clog2(PEND_MAX + 2);

	logic [PEND_W-1:0] pending_q;
	logic              in_last, out_take;

	assign in_last  = s_tvalid && s_tready && s_tlast;
	assign out_take = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + PEND_W'(in_last) - PEND_W'(out_take);
		end
	end

	`VDU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output item changed while stalled")
	`VDU_ASSERT_SAME(a_out_cause, m_tvalid, pending_q != '0, "result without a finished vector")
	`VDU_ASSERT_SAME(a_backlog, 1'b1, pending_q <= PEND_W'(PEND_MAX), "more vectors in flight than storage")
	`VDU_ASSERT_SAME(a_out_fill, m_tvalid, m_tdata[OUT_TDATA_W-1:DIST_W] == '0, "fill bits of result not zero")

endmodule

bind vector_distance_unit vdu_checker u_vdu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
